@@ src/ffpa_pkg.sv @@
// package of shared types and constants for the first-fit pool allocator
`default_nettype none
package ffpa_pkg;

  // defaults for the top-level parameters
  localparam int unsigned DEF_POOL_BYTES   = 65536;
  localparam int unsigned DEF_HEADER_BYTES = 24;

  // fixed field widths
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned REQ_W   = 17;
  localparam int unsigned OFF_W   = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned NEED_W  = 15;
  localparam int unsigned S_DATA_W = 40;
  localparam int unsigned M_DATA_W = 24;
  localparam logic [CFG_W-1:0] RESET_POOL_BYTES = 17'd65536;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADOFF  = 2'd2;

  // controller states
  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_ACHK  = 14'b00000000000100,
    S_AEV   = 14'b00000000001000,
    S_ATAKE = 14'b00000000010000,
    S_FCHK  = 14'b00000000100000,
    S_FEVB  = 14'b00000001000000,
    S_FWCHK = 14'b00000010000000,
    S_FWEV  = 14'b00000100000000,
    S_FNCHK = 14'b00001000000000,
    S_FNEV  = 14'b00010000000000,
    S_FFIN  = 14'b00100000000000,
    S_FFIN2 = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_RD_U,
    OP_STEP,
    OP_SPLIT,
    OP_TAKE,
    OP_NOSPACE,
    OP_BAD,
    OP_RD_BLK,
    OP_SAVE_BLK,
    OP_PSTEP,
    OP_RD_NXT,
    OP_MERGE_NXT,
    OP_FIN_BLK,
    OP_FIN_PREV
  } op_t;

  // controller to datapath
  typedef struct packed {
    op_t  op;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_free;
    logic clr_last;
    logic u_end;
    logic len_zero;
    logic fits;
    logic split;
    logic off_bad;
    logic blk_bad;
    logic u_lt_blk;
    logic nxt_in;
    logic nxt_merge;
    logic merge_prev;
    logic out_busy;
  } sts_t;

endpackage
`default_nettype wire

@@ src/ffpa_dp.sv @@
// datapath: block table memory, walk registers, result and output register
`default_nettype none
module ffpa_dp
  import ffpa_pkg::*;
#(
  parameter int unsigned POOL_BYTES   = DEF_POOL_BYTES,
  parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic                s_tuser,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata
);

  localparam int unsigned UNITS = POOL_BYTES / 8;
  localparam int unsigned AW    = $clog2(UNITS);
  localparam int unsigned LW    = $clog2(UNITS + 1);
  localparam int unsigned CMPW  = (LW > NEED_W) ? LW : NEED_W;
  localparam int unsigned PBW   = $clog2(POOL_BYTES + 1);
  localparam int unsigned CW    = (PBW > CFG_W) ? PBW : CFG_W;
  localparam int unsigned OW    = (LW + 3 > OFF_W) ? LW + 3 : OFF_W;
  localparam int unsigned MIN_U = (HEADER_BYTES + 8 + 7) / 8;
  localparam int unsigned EW    = LW + 2;

  // block table: {start, free, length in units}
  logic [EW-1:0] mem [UNITS];
  logic [EW-1:0] rdata;

  logic [LW-1:0]     pool_units;
  logic [AW-1:0]     clr_cnt;
  logic [LW-1:0]     u;
  logic [AW-1:0]     blk;
  logic [AW-1:0]     prev;
  logic [LW-1:0]     prev_len;
  logic              prev_free;
  logic              have_prev;
  logic [LW-1:0]     len_blk;
  logic [NEED_W-1:0] need;
  logic              off_bad;
  logic [STAT_W-1:0] res_status;
  logic [OFF_W-1:0]  res_off;

  // read entry fields
  logic [LW-1:0] rd_len;
  logic          rd_free;
  logic          rd_start;
  assign rd_len   = rdata[LW-1:0];
  assign rd_free  = rdata[LW];
  assign rd_start = rdata[LW+1];

  // clamp of a written pool size
  logic [CW-1:0] cfg_ext;
  logic [CW-1:0] cfg_clamp;
  always_comb begin
    cfg_ext = CW'(cfg_wdata);
    if (cfg_ext < CW'(32)) cfg_clamp = CW'(32);
    else if (cfg_ext > CW'(POOL_BYTES)) cfg_clamp = CW'(POOL_BYTES);
    else cfg_clamp = cfg_ext;
  end

  // reset pool size
  localparam int unsigned RST_BYTES =
    (int'(RESET_POOL_BYTES) > POOL_BYTES) ? POOL_BYTES : int'(RESET_POOL_BYTES);

  // incoming item decode
  logic [REQ_W-1:0] in_req;
  logic [OFF_W-1:0] in_off;
  logic [17:0]      sum;
  logic [17:0]      sum_min;
  logic [17:0]      sum_rnd;
  logic [OFF_W-1:0] in_byte;
  logic [CW-1:0]    in_blk_w;
  logic             in_bad;
  always_comb begin
    in_req   = s_tdata[REQ_W-1:0];
    in_off   = s_tdata[REQ_W+OFF_W-1:REQ_W];
    sum      = 18'(in_req) + 18'(HEADER_BYTES);
    sum_min  = (sum < 18'(HEADER_BYTES + 8)) ? 18'(HEADER_BYTES + 8) : sum;
    sum_rnd  = sum_min + 18'd7;
    in_byte  = in_off - OFF_W'(HEADER_BYTES);
    in_blk_w = CW'(in_byte[OFF_W-1:3]);
    in_bad   = (in_off < OFF_W'(HEADER_BYTES)) || (in_byte[2:0] != 3'd0) ||
               (in_blk_w >= CW'(pool_units));
  end

  // walk arithmetic
  logic [LW-1:0] need_l;
  logic [LW-1:0] rest;
  logic [LW-1:0] nxt;
  logic          split;
  logic          merge_prev;
  logic [OW-1:0] off_w;
  always_comb begin
    need_l     = LW'(need);
    rest       = rd_len - need_l;
    split      = rest >= LW'(MIN_U);
    nxt        = LW'(blk) + len_blk;
    merge_prev = have_prev && prev_free && ((LW'(prev) + prev_len) == LW'(blk));
    off_w      = OW'({u, 3'b000}) + OW'(HEADER_BYTES);
  end

  // status to the controller
  always_comb begin
    sts.in_free    = s_tuser;
    sts.clr_last   = clr_cnt == AW'(UNITS - 1);
    sts.u_end      = u >= pool_units;
    sts.len_zero   = rd_len == '0;
    sts.fits       = rd_free && (CMPW'(rd_len) >= CMPW'(need));
    sts.split      = split;
    sts.off_bad    = off_bad;
    sts.blk_bad    = !rd_start || rd_free;
    sts.u_lt_blk   = u < LW'(blk);
    sts.nxt_in     = nxt < pool_units;
    sts.nxt_merge  = rd_start && rd_free;
    sts.merge_prev = merge_prev;
    sts.out_busy   = m_tvalid && !m_tready;
  end

  // memory port selection
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  always_comb begin
    rd_en = 1'b0;
    raddr = u[AW-1:0];
    we    = 1'b0;
    waddr = u[AW-1:0];
    wdata = '0;
    case (cmd.op)
      OP_RD_U: begin
        rd_en = 1'b1;
      end
      OP_RD_BLK: begin
        rd_en = 1'b1;
        raddr = blk;
      end
      OP_RD_NXT: begin
        rd_en = 1'b1;
        raddr = nxt[AW-1:0];
      end
      OP_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = (clr_cnt == '0) ? {2'b11, pool_units} : '0;
      end
      OP_SPLIT: begin
        we    = 1'b1;
        waddr = AW'(u + need_l);
        wdata = {2'b11, rest};
      end
      OP_TAKE: begin
        we    = 1'b1;
        wdata = {2'b10, (split ? need_l : rd_len)};
      end
      OP_MERGE_NXT: begin
        we    = 1'b1;
        waddr = nxt[AW-1:0];
      end
      OP_FIN_BLK: begin
        we    = 1'b1;
        waddr = blk;
        wdata = merge_prev ? '0 : {2'b11, len_blk};
      end
      OP_FIN_PREV: begin
        we    = 1'b1;
        waddr = prev;
        wdata = {2'b11, prev_len + len_blk};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd_en) rdata <= mem[raddr];
  end

  // pool size and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_units <= LW'(RST_BYTES / 8);
      clr_cnt    <= '0;
    end else if (cfg_we) begin
      pool_units <= LW'(cfg_clamp[CW-1:3]);
      clr_cnt    <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        need      <= sum_rnd[17:3];
        off_bad   <= in_bad;
        blk       <= in_blk_w[AW-1:0];
        u         <= '0;
        have_prev <= 1'b0;
      end
      OP_STEP: begin
        u <= u + rd_len;
      end
      OP_PSTEP: begin
        prev      <= u[AW-1:0];
        prev_len  <= rd_len;
        prev_free <= rd_free;
        have_prev <= 1'b1;
        u         <= u + rd_len;
      end
      OP_SAVE_BLK: begin
        len_blk <= rd_len;
      end
      OP_MERGE_NXT: begin
        len_blk <= len_blk + rd_len;
      end
      OP_TAKE: begin
        res_status <= ST_DONE;
        res_off    <= off_w[OFF_W-1:0];
      end
      OP_NOSPACE: begin
        res_status <= ST_NOSPACE;
        res_off    <= '0;
      end
      OP_BAD: begin
        res_status <= ST_BADOFF;
        res_off    <= '0;
      end
      OP_FIN_BLK: begin
        res_status <= ST_DONE;
        res_off    <= '0;
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= M_DATA_W'({res_off, res_status});
  end

endmodule
`default_nettype wire

@@ src/ffpa_ctrl.sv @@
// controller state machine sequencing allocate, free and table clearing
`default_nettype none
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output cmd_t      cmd,
  input  wire sts_t sts
);

  state_t state;
  state_t state_next;

  assign s_tready = state == S_IDLE;

  // next state and datapath command
  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = OP_LOAD;
          state_next = sts.in_free ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts.u_end) begin
          cmd.op     = OP_NOSPACE;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_RD_U;
          state_next = S_AEV;
        end
      end
      S_AEV: begin
        if (sts.len_zero) begin
          cmd.op     = OP_NOSPACE;
          state_next = S_OUT;
        end else if (sts.fits) begin
          if (sts.split) cmd.op = OP_SPLIT;
          state_next = S_ATAKE;
        end else begin
          cmd.op     = OP_STEP;
          state_next = S_ACHK;
        end
      end
      S_ATAKE: begin
        cmd.op     = OP_TAKE;
        state_next = S_OUT;
      end
      S_FCHK: begin
        if (sts.off_bad) begin
          cmd.op     = OP_BAD;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_RD_BLK;
          state_next = S_FEVB;
        end
      end
      S_FEVB: begin
        if (sts.blk_bad) begin
          cmd.op     = OP_BAD;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_SAVE_BLK;
          state_next = S_FWCHK;
        end
      end
      S_FWCHK: begin
        if (sts.u_lt_blk) begin
          cmd.op     = OP_RD_U;
          state_next = S_FWEV;
        end else begin
          state_next = S_FNCHK;
        end
      end
      S_FWEV: begin
        if (sts.len_zero) begin
          state_next = S_FNCHK;
        end else begin
          cmd.op     = OP_PSTEP;
          state_next = S_FWCHK;
        end
      end
      S_FNCHK: begin
        if (sts.nxt_in) begin
          cmd.op     = OP_RD_NXT;
          state_next = S_FNEV;
        end else begin
          state_next = S_FFIN;
        end
      end
      S_FNEV: begin
        if (sts.nxt_merge) cmd.op = OP_MERGE_NXT;
        state_next = S_FFIN;
      end
      S_FFIN: begin
        cmd.op     = OP_FIN_BLK;
        state_next = sts.merge_prev ? S_FFIN2 : S_OUT;
      end
      S_FFIN2: begin
        cmd.op     = OP_FIN_PREV;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    // a pool size write restarts the clearing pass
    if (cfg_we) begin
      state_next   = S_CLEAR;
      cmd.out_load = 1'b0;
      cmd.op       = OP_NONE;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

`ifndef ASSERT_OFF
  // result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy) else $error("result register overwritten");

  // an accepted transaction starts a walk
  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !cfg_we) |=> (state == S_ACHK || state == S_FCHK))
    else $error("accepted transaction did not start a walk");

  // a pool size write always leads to clearing
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> state == S_CLEAR) else $error("pool write did not start clearing");
`endif

endmodule
`default_nettype wire

@@ src/first_fit_pool_allocator_core.sv @@
// Top level of the first-fit pool allocator.
// Allocate walks the blocks up to the first fit; free walks the blocks in front of
// the freed one, then merges it with its free neighbors.
// One transaction at a time; the block walk over the table sets the rate.
// Reset and every pool_bytes write run a clearing pass over the whole table
// with s_tready low; the output register is emptied by reset.
`default_nettype none
module first_fit_pool_allocator_core
  import ffpa_pkg::*;
#(
  parameter int unsigned POOL_BYTES   = DEF_POOL_BYTES,
  parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // request_bytes, release_offset, zero pad
  input  wire logic                s_tuser,  // command
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata   // status, data_offset, zero pad
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // table and arithmetic
  ffpa_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the first-fit pool allocator core
`timescale 1ns / 100ps
module testbench;
  import ffpa_pkg::*;

  localparam int unsigned UNITS = DEF_POOL_BYTES / 8;
  localparam int unsigned HDR = DEF_HEADER_BYTES;
  localparam int unsigned MIN_BLK = DEF_HEADER_BYTES + 8;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFF_W-1:0]  data_offset;
  } answer_t;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;  // request_bytes, release_offset, zero pad
  logic                s_tuser;  // command
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;  // status, data_offset, zero pad

  // allocator model state, one entry per 8-byte unit
  bit          blk_start[UNITS];
  int unsigned blk_len[UNITS];
  bit          blk_free[UNITS];
  int unsigned pool_units;

  answer_t        answers_due[$];
  logic [OFF_W-1:0] live_offsets[$];
  logic [OFF_W-1:0] freed_offsets[$];
  int             fail_count = 0;
  int             burst_left;

  first_fit_pool_allocator_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // rebuild the pool as one free block
  function automatic void pool_reinit(int unsigned bytes);
    if (bytes < 32) bytes = 32;
    if (bytes > DEF_POOL_BYTES) bytes = DEF_POOL_BYTES;
    pool_units = bytes / 8;
    for (int i = 0; i < UNITS; i++) begin
      blk_start[i] = 1'b0;
      blk_len[i] = 0;
      blk_free[i] = 1'b0;
    end
    blk_start[0] = 1'b1;
    blk_len[0] = pool_units;
    blk_free[0] = 1'b1;
  endfunction

  // first-fit allocation with split of a large enough remainder
  function automatic answer_t model_alloc(int unsigned req);
    answer_t     a;
    int unsigned need;
    int unsigned u;
    int unsigned len;
    int unsigned rest;
    a.status = ST_NOSPACE;
    a.data_offset = '0;
    need = req + HDR;
    u = 0;
    if (need < MIN_BLK) need = MIN_BLK;
    need = ((need + 7) & ~32'd7) / 8;
    while (u < pool_units) begin
      len = blk_len[u];
      if (len == 0) break;
      if (blk_free[u] && len >= need) begin
        rest = len - need;
        if (rest * 8 >= MIN_BLK && u + need < UNITS) begin
          blk_start[u + need] = 1'b1;
          blk_len[u + need] = rest;
          blk_free[u + need] = 1'b1;
          blk_len[u] = need;
        end
        blk_free[u] = 1'b0;
        a.status = ST_DONE;
        a.data_offset = OFF_W'(u * 8 + HDR);
        return a;
      end
      u += len;
    end
    return a;
  endfunction

  // release with merge into free neighbors
  function automatic answer_t model_free(int unsigned off);
    answer_t     a;
    int unsigned blk;
    int unsigned u;
    int unsigned prev;
    int unsigned nxt;
    bit          have_prev;
    a.status = ST_BADOFF;
    a.data_offset = '0;
    u = 0;
    prev = 0;
    have_prev = 1'b0;
    if (off < HDR || ((off - HDR) & 7) != 0) return a;
    blk = (off - HDR) / 8;
    if (blk >= pool_units || !blk_start[blk] || blk_free[blk]) return a;
    while (u < blk) begin
      if (blk_len[u] == 0) break;
      prev = u;
      have_prev = 1'b1;
      u += blk_len[u];
    end
    blk_free[blk] = 1'b1;
    nxt = blk + blk_len[blk];
    if (nxt < pool_units && blk_start[nxt] && blk_free[nxt]) begin
      blk_len[blk] += blk_len[nxt];
      blk_start[nxt] = 1'b0;
      blk_len[nxt] = 0;
      blk_free[nxt] = 1'b0;
    end
    if (have_prev && blk_free[prev] && prev + blk_len[prev] == blk) begin
      blk_len[prev] += blk_len[blk];
      blk_start[blk] = 1'b0;
      blk_len[blk] = 0;
      blk_free[blk] = 1'b0;
    end
    a.status = ST_DONE;
    return a;
  endfunction

  // drop s_tvalid so nothing more is offered
  task automatic hold_input();
    s_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // offer one command, wait for its transaction, then maybe gap
  task automatic send_cmd(logic cmd, logic [REQ_W-1:0] req, logic [OFF_W-1:0] off);
    answer_t a;
    int      gap;
    if (cmd == CMD_ALLOC) begin
      a = model_alloc(req);
      if (a.status == ST_DONE) live_offsets.push_back(a.data_offset);
    end else begin
      a = model_free(off);
    end
    answers_due.push_back(a);
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {{(S_DATA_W-REQ_W-OFF_W){1'b0}}, off, req};
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 30);
    end
  endtask

  // wait for the pipe to drain, then write pool_bytes
  task automatic write_pool(logic [CFG_W-1:0] bytes);
    hold_input();
    while (answers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= bytes;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_reinit(bytes);
    live_offsets.delete();
    freed_offsets.delete();
  endtask

  // free a live offset chosen at random
  task automatic free_live();
    int idx;
    logic [OFF_W-1:0] off;
    idx = $urandom_range(0, live_offsets.size() - 1);
    off = live_offsets[idx];
    live_offsets.delete(idx);
    freed_offsets.push_back(off);
    if (freed_offsets.size() > 16) void'(freed_offsets.pop_front());
    send_cmd(CMD_FREE, REQ_W'($urandom_range(0, 131071)), off);
  endtask

  // field extremes, minimum block, oversize request, min and max pool
  task automatic test_alloc_extremes();
    send_cmd(CMD_ALLOC, 17'd0, 16'd0);
    send_cmd(CMD_ALLOC, 17'd8, 16'hffff);
    send_cmd(CMD_ALLOC, 17'd9, 16'd0);
    send_cmd(CMD_ALLOC, 17'h1ffff, 16'd0);
    send_cmd(CMD_ALLOC, 17'd65000, 16'd0);
    write_pool(17'd0);
    send_cmd(CMD_ALLOC, 17'd0, 16'd0);
    write_pool(17'd40);
    send_cmd(CMD_ALLOC, 17'd8, 16'd0);
    send_cmd(CMD_ALLOC, 17'd0, 16'd0);
    write_pool(17'h1ffff);
    send_cmd(CMD_ALLOC, 17'd65512, 16'd0);
    send_cmd(CMD_ALLOC, 17'd0, 16'd0);
  endtask

  // bad offsets, double free, merged-away offsets
  task automatic test_free_cases();
    write_pool(17'd1000);
    send_cmd(CMD_FREE, 17'h1ffff, 16'd0);
    send_cmd(CMD_FREE, 17'd0, 16'd23);
    send_cmd(CMD_FREE, 17'd0, 16'd25);
    send_cmd(CMD_FREE, 17'd0, 16'd1024);
    send_cmd(CMD_FREE, 17'd0, 16'hffff);
    repeat (4) send_cmd(CMD_ALLOC, 17'd40, 16'd0);
    send_cmd(CMD_FREE, 17'd0, 16'd88);
    send_cmd(CMD_FREE, 17'd0, 16'd88);
    send_cmd(CMD_FREE, 17'd0, 16'd24);
    send_cmd(CMD_FREE, 17'd0, 16'd152);
    send_cmd(CMD_FREE, 17'd0, 16'd88);
    send_cmd(CMD_FREE, 17'd0, 16'd216);
    send_cmd(CMD_ALLOC, 17'd900, 16'd0);
  endtask

  // random alloc and free traffic over one pool size
  task automatic test_random_traffic(logic [CFG_W-1:0] bytes, int count);
    int pick;
    write_pool(bytes);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (live_offsets.size() == 0 || pick < 48) begin
        pick = $urandom_range(0, 99);
        send_cmd(CMD_ALLOC, REQ_W'((pick < 80) ? $urandom_range(0, 512) :
                 (pick < 95) ? $urandom_range(0, 4096) : $urandom_range(0, 131071)),
                 OFF_W'($urandom_range(0, 65535)));
      end else if (pick < 88) begin
        free_live();
      end else if (pick < 94 && freed_offsets.size() != 0) begin
        send_cmd(CMD_FREE, REQ_W'($urandom_range(0, 131071)),
                 freed_offsets[$urandom_range(0, freed_offsets.size() - 1)]);
      end else begin
        send_cmd(CMD_FREE, REQ_W'($urandom_range(0, 131071)),
                 OFF_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  // receiver stall pattern with quiet stretches
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // result check against the oldest expected answer
  always @(posedge clk) begin
    answer_t a;
    if (!rst && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result transaction, tdata=%h", m_tdata);
        fail_count++;
      end else begin
        a = answers_due.pop_front();
        if (m_tdata[STAT_W-1:0] !== a.status) begin
          $error("status: expected %0d, actual %0d", a.status, m_tdata[STAT_W-1:0]);
          fail_count++;
        end
        if (m_tdata[STAT_W+OFF_W-1:STAT_W] !== a.data_offset) begin
          $error("data_offset: expected %0d, actual %0d", a.data_offset,
                 m_tdata[STAT_W+OFF_W-1:STAT_W]);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #400ms;
    $display("Regression FAIL");
    $finish;
  end

  // test sequence
  initial begin
    burst_left = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_ALLOC;
    pool_reinit(RESET_POOL_BYTES);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_alloc_extremes();
    test_free_cases();
    test_random_traffic(17'd65536, 400);
    test_random_traffic(17'd4096, 250);
    test_random_traffic(17'd256, 100);
    test_random_traffic(17'd70000, 200);
    hold_input();
    while (answers_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
